[rtl/ept_pkg.sv]
// ----------------------------------------------------------------------------
// ept_pkg
// Shared widths, codes and control types of the encoder position and
// velocity tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ept_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int CNT_W        = 16;
  localparam int WRAP_W       = 16;
  localparam int POS_W        = 32;
  localparam int CPR_W        = 18;
  localparam int RPC_W        = 32;
  localparam int ALPHA_W      = 17;
  localparam int ANG_W        = 25;
  localparam int VEL_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CNT_W-1:0] CNT_MASK = (COUNTER_BITS >= CNT_W) ? {CNT_W{1'b1}} :
                                          CNT_W'((64'd1 << COUNTER_BITS) - 64'd1);

  localparam logic [CPR_W-1:0]   CPR_RESET   = 18'd1600;
  localparam logic [RPC_W-1:0]   RPC_RESET   = 32'd245760;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd19661;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;

  // 360 degrees in Q9.16
  localparam logic [ANG_W-1:0] DEG_SCALE = 25'd23592960;

  // shared divider: 43-bit dividend covers pin * DEG_SCALE
  localparam int DIV_W     = CPR_W + ANG_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_CNT_W-1:0] MOD_STEPS = DIV_CNT_W'(POS_W);
  localparam logic [DIV_CNT_W-1:0] ANG_STEPS = DIV_CNT_W'(DIV_W);

  // stream payloads
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_POS_LSB = 0;
  localparam int OUT_PIN_LSB = OUT_POS_LSB + POS_W;
  localparam int OUT_ANG_LSB = OUT_PIN_LSB + CPR_W;
  localparam int OUT_VF_LSB  = OUT_ANG_LSB + ANG_W;
  localparam int OUT_VR_LSB  = OUT_VF_LSB + VEL_W;
  localparam int OUT_REV_BIT = OUT_VR_LSB + VEL_W;
  localparam int OUT_USED_W  = OUT_REV_BIT + 1;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    MODE_WRAP  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_VEL   = 2'd2,
    MODE_RESET = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPR   = 2'd0,
    CFG_RPC   = 2'd1,
    CFG_ALPHA = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VMUL,
    ST_VSAT,
    ST_VPROD,
    ST_VSUM,
    ST_MSTART,
    ST_MWAIT,
    ST_AMUL,
    ST_ASTART,
    ST_AWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic vel_mul;
    logic vel_sat;
    logic vel_prod;
    logic vel_sum;
    logic mod_start;
    logic mod_cap;
    logic ang_mul;
    logic ang_start;
    logic ang_cap;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_vel;
    logic cpr_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/ept_divider.sv]
// ----------------------------------------------------------------------------
// ept_divider
// Radix-2 restoring divider, one quotient bit per cycle, shared by the
// modulo and the angle computation.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_divider
  import ept_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_CNT_W-1:0] nsteps_i,
  input  wire logic [DIV_W-1:0]     dividend_i,
  input  wire logic [CPR_W-1:0]     divisor_i,
  output logic                      done_o,
  output logic [DIV_W-1:0]          quotient_o,
  output logic [CPR_W-1:0]          remainder_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [CPR_W-1:0]     rem_q, rem_d;
  logic [CPR_W:0]       trial;
  logic [CPR_W:0]       diff;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, dvd_q[DIV_W-1]};
    diff   = trial - {1'b0, divisor_i};
    ge     = (trial >= {1'b0, divisor_i});
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = nsteps_i;
      busy_d = 1'b1;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift the quotient bit in where the dividend bit leaves
      dvd_d = {dvd_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[CPR_W-1:0] : trial[CPR_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[rtl/ept_ctrl.sv]
// ----------------------------------------------------------------------------
// ept_ctrl
// Sequencer of the tracker: accepts one event, steps the velocity filter
// on velocity samples, modulo and angle division if CPR is set, then output.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_ctrl
  import ept_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  input  wire dp_status_t status_i,
  output logic            s_ready_o,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = status_i.in_vel ? ST_VMUL : ST_MSTART;
        end
      end
      ST_VMUL:   state_d = ST_VSAT;
      ST_VSAT:   state_d = ST_VPROD;
      ST_VPROD:  state_d = ST_VSUM;
      ST_VSUM:   state_d = ST_MSTART;
      ST_MSTART: state_d = status_i.cpr_zero ? ST_DONE : ST_MWAIT;
      ST_MWAIT: begin
        if (status_i.div_done) begin
          state_d = ST_AMUL;
        end
      end
      ST_AMUL:   state_d = ST_ASTART;
      ST_ASTART: state_d = ST_AWAIT;
      ST_AWAIT: begin
        if (status_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    s_ready_o       = (state_q == ST_IDLE);
    cmd_o.accept    = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.vel_mul   = (state_q == ST_VMUL);
    cmd_o.vel_sat   = (state_q == ST_VSAT);
    cmd_o.vel_prod  = (state_q == ST_VPROD);
    cmd_o.vel_sum   = (state_q == ST_VSUM);
    cmd_o.mod_start = (state_q == ST_MSTART) && !status_i.cpr_zero;
    cmd_o.mod_cap   = (state_q == ST_MWAIT) && status_i.div_done;
    cmd_o.ang_mul   = (state_q == ST_AMUL);
    cmd_o.ang_start = (state_q == ST_ASTART);
    cmd_o.ang_cap   = (state_q == ST_AWAIT) && status_i.div_done;
    cmd_o.out_load  = (state_q == ST_DONE) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ept_datapath.sv]
// ----------------------------------------------------------------------------
// ept_datapath
// Configuration, position and velocity state, velocity filter arithmetic,
// modulo and angle through the shared divider, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_datapath
  import ept_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  input  wire logic [IN_DATA_W-1:0]  s_data_i,
  input  wire logic [IN_USER_W-1:0]  s_user_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output logic [OUT_DATA_W-1:0]      m_data_o
);

  // configuration
  logic [CPR_W-1:0]   cpr_q;
  logic [RPC_W-1:0]   rpc_q;
  logic [ALPHA_W-1:0] alpha_q;

  // tracker state
  logic [WRAP_W-1:0]       wrap_q;
  logic [POS_W-1:0]        prev_q;
  logic signed [VEL_W-1:0] filt_q;
  logic signed [VEL_W-1:0] raw_q;
  logic                    rev_q;

  // per-event working registers
  logic [POS_W-1:0]                 pos_q;
  logic                             zs_q;
  logic signed [POS_W+RPC_W:0]      prod_q;
  logic signed [VEL_W-1:0]          rawt_q;
  logic signed [ALPHA_W+VEL_W:0]    pa_q, pb_q;
  logic [CPR_W-1:0]                 pin_q;
  logic [ANG_W-1:0]                 ang_q;
  logic [DIV_W-1:0]                 angp_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // input decode
  mode_e             mode;
  logic [CNT_W-1:0]  cnt_eff;
  logic              down;
  logic [WRAP_W-1:0] wrap_next;
  logic [POS_W-1:0]  pos_new;

  always_comb begin
    mode    = mode_e'(s_user_i);
    down    = s_data_i[CNT_W];
    cnt_eff = (mode == MODE_RESET) ? '0 : (s_data_i[CNT_W-1:0] & CNT_MASK);
    case (mode)
      MODE_WRAP:  wrap_next = down ? wrap_q - WRAP_W'(1) : wrap_q + WRAP_W'(1);
      MODE_RESET: wrap_next = '0;
      default:    wrap_next = wrap_q;
    endcase
    pos_new = POS_W'({{(POS_W-WRAP_W){wrap_next[WRAP_W-1]}}, wrap_next} << COUNTER_BITS)
            + POS_W'(cnt_eff);
  end

  // velocity arithmetic
  logic [POS_W-1:0]              delta;
  logic signed [POS_W+RPC_W:0]   prod_d;
  logic signed [VEL_W-1:0]       rawt_d;
  logic [ALPHA_W-1:0]            a_sat, b_w;
  logic signed [ALPHA_W+VEL_W:0] pa_d, pb_d;
  logic signed [ALPHA_W+VEL_W:0] fsum;

  always_comb begin
    delta  = pos_q - prev_q;
    prod_d = $signed(delta) * $signed({1'b0, rpc_q});
    // floor shift by 8, then clamp to 32 bits
    if (prod_q[POS_W+RPC_W:VEL_W+7] == {(POS_W+RPC_W-VEL_W-6){prod_q[POS_W+RPC_W]}}) begin
      rawt_d = prod_q[VEL_W+7:8];
    end else begin
      rawt_d = prod_q[POS_W+RPC_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end
    a_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
    b_w   = ALPHA_ONE - a_sat;
    pa_d  = $signed({1'b0, a_sat}) * rawt_q;
    pb_d  = $signed({1'b0, b_w}) * filt_q;
    fsum  = pa_q + pb_q;
  end

  // shared divider
  logic [POS_W-1:0] mag;
  logic [DIV_W-1:0] div_dividend;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  logic [CPR_W-1:0] div_rem;

  assign mag          = pos_q[POS_W-1] ? (~pos_q + POS_W'(1)) : pos_q;
  assign div_dividend = cmd_i.ang_start ? angp_q : {mag, {(DIV_W-POS_W){1'b0}}};

  ept_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.mod_start | cmd_i.ang_start),
    .nsteps_i    (cmd_i.ang_start ? ANG_STEPS : MOD_STEPS),
    .dividend_i  (div_dividend),
    .divisor_i   (cpr_q),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q   <= CPR_RESET;
      rpc_q   <= RPC_RESET;
      alpha_q <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CPR:   cpr_q   <= cfg_data_i[CPR_W-1:0];
        CFG_RPC:   rpc_q   <= cfg_data_i[RPC_W-1:0];
        CFG_ALPHA: alpha_q <= cfg_data_i[ALPHA_W-1:0];
        default:   ;
      endcase
    end
  end

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= '0;
      prev_q <= '0;
      filt_q <= '0;
      raw_q  <= '0;
      rev_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      wrap_q <= wrap_next;
      if (mode == MODE_RESET) begin
        prev_q <= '0;
        filt_q <= '0;
        raw_q  <= '0;
      end
    end else if (cmd_i.vel_sum) begin
      filt_q <= fsum[VEL_W+15:16];
      raw_q  <= rawt_q;
      rev_q  <= fsum[ALPHA_W+VEL_W];
      prev_q <= pos_q;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q <= pos_new;
      zs_q  <= (mode == MODE_VEL) && (rpc_q == '0);
    end
    if (cmd_i.vel_mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.vel_sat) begin
      rawt_q <= rawt_d;
    end
    if (cmd_i.vel_prod) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (cmd_i.mod_cap) begin
      // fold a negative position back into range
      pin_q <= (pos_q[POS_W-1] && (div_rem != '0)) ? cpr_q - div_rem : div_rem;
    end
    if (cmd_i.ang_mul) begin
      angp_q <= DIV_W'(pin_q) * DIV_W'(DEG_SCALE);
    end
    if (cmd_i.ang_cap) begin
      ang_q <= div_quot[ANG_W-1:0];
    end
  end

  // output register
  logic            cpr_zero;
  logic [OUT_DATA_W-1:0] out_pack;

  assign cpr_zero = (cpr_q == '0);

  always_comb begin
    out_pack = '0;
    out_pack[OUT_POS_LSB +: POS_W] = pos_q;
    out_pack[OUT_PIN_LSB +: CPR_W] = cpr_zero ? '0 : pin_q;
    out_pack[OUT_ANG_LSB +: ANG_W] = cpr_zero ? '0 : ang_q;
    out_pack[OUT_VF_LSB +: VEL_W]  = zs_q ? '0 : filt_q;
    out_pack[OUT_VR_LSB +: VEL_W]  = zs_q ? '0 : raw_q;
    out_pack[OUT_REV_BIT]          = rev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_pack;
    end
  end

  assign m_valid_o         = out_valid_q;
  assign m_data_o          = out_data_q;
  assign status_o.in_vel   = (mode == MODE_VEL) && (rpc_q != '0);
  assign status_o.cpr_zero = cpr_zero;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || m_ready_i;

endmodule

`default_nettype wire

[rtl/encoder_position_velocity_tracker.sv]
// ----------------------------------------------------------------------------
// encoder_position_velocity_tracker
// Extends a quadrature counter to a 32-bit position, gives position within
// one revolution and its angle, and tracks a filtered velocity.
// ----------------------------------------------------------------------------
//  channel  | signals                            | role
//  s_axis   | tvalid tready tdata tuser          | event in
//  m_axis   | tvalid tready tdata                | result out, one per event
//  cfg      | cfg_we_i cfg_idx_i cfg_data_i      | register write
//
//  An event runs the velocity filter steps when it is a velocity sample with
//  nonzero RPC, then the modulo and angle division, which a zero revolution
//  size skips. Both divisions use the shared radix-2 divider: 32 steps for
//  the modulo, 43 steps for the angle. One event is in work at a time; the
//  next event is taken while the previous result waits in the output
//  register. Reset is asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_position_velocity_tracker
  import ept_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [15:0] counter_value, [16] counting_down, [23:17] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [31:0] position, [49:32] position_in_rev, [74:50] angle_degrees,
  // [106:75] velocity_filtered, [138:107] unfiltered velocity, [139] reverse,
  // [143:140] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ept_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  ept_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

[rtl/ept_checker.sv]
// ----------------------------------------------------------------------------
// ept_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ept_checker
  import ept_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // one event in work at a time
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("event taken while another is in work");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_ANG_LSB +: ANG_W] < DEG_SCALE))
    else $error("angle beyond one revolution");

  // direction follows filtered sign unless both velocity fields are zero
  a_dir_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_REV_BIT] == m_axis_tdata[OUT_VF_LSB + VEL_W - 1]) ||
                      (m_axis_tdata[OUT_VF_LSB +: 2*VEL_W] == '0))
    else $error("direction disagrees with filtered velocity");

endmodule

bind encoder_position_velocity_tracker ept_checker u_ept_checker (.*);

`default_nettype wire

[dv/tb_encoder_position_velocity_tracker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_position_velocity_tracker
// Self-checking testbench: drives encoder events into the tracker, predicts
// every result with its own position, modulo, angle and velocity filter
// model, and compares each output transfer field by field, under random
// input gaps, output stalls and a long output hold-off.
// ----------------------------------------------------------------------------

module tb_encoder_position_velocity_tracker
  import ept_pkg::*;
();

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic [POS_W-1:0] pos;
    logic [CPR_W-1:0] pin;
    logic [ANG_W-1:0] ang;
    logic [VEL_W-1:0] vf;
    logic [VEL_W-1:0] vr;
    logic             rev;
  } track_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  encoder_position_velocity_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tracker model: registers and state
  logic [CPR_W-1:0]   cpr_reg   = CPR_RESET;
  logic [RPC_W-1:0]   rpc_reg   = RPC_RESET;
  logic [ALPHA_W-1:0] alpha_reg = ALPHA_RESET;
  logic [WRAP_W-1:0]  wrap_cnt  = '0;
  logic [POS_W-1:0]   sample_pos = '0;
  logic [VEL_W-1:0]   vel_filt  = '0;
  logic [VEL_W-1:0]   vel_raw   = '0;
  logic               rev_dir   = 1'b0;

  track_result_t pending_results[$];
  int            mismatches = 0;
  int            sent_items = 0;
  int            burst_left = 0;
  int            hold_requests = 0;
  int            holds_served = 0;
  int            stall_left = 0;
  int            style_left = 0;
  int            stall_style = 0;
  int            idle_cycles = 0;

  function automatic track_result_t track_event(mode_e mode, logic [CNT_W-1:0] cnt,
                                                logic down);
    track_result_t    r;
    logic [CNT_W-1:0] c;
    logic [POS_W-1:0] p;
    longint           w, cl, delta, rpc_l, raw_l, a, filt_l, cpr_l, rem, deg;
    c = cnt & CNT_MASK;
    if (mode == MODE_WRAP) begin
      wrap_cnt = down ? wrap_cnt - 1'b1 : wrap_cnt + 1'b1;
    end
    if (mode == MODE_RESET) begin
      wrap_cnt   = '0;
      sample_pos = '0;
      vel_filt   = '0;
      vel_raw    = '0;
      c          = '0;
    end
    w  = longint'($signed(wrap_cnt));
    cl = c;
    p  = POS_W'((w << COUNTER_BITS) + cl);
    r.vf = vel_filt;
    r.vr = vel_raw;
    if (mode == MODE_VEL) begin
      if (rpc_reg == '0) begin
        r.vf = '0;
        r.vr = '0;
      end else begin
        delta = longint'($signed(p - sample_pos));
        rpc_l = rpc_reg;
        raw_l = (delta * rpc_l) >>> 8;
        if (raw_l > 64'sd2147483647) raw_l = 64'sd2147483647;
        if (raw_l < -64'sd2147483648) raw_l = -64'sd2147483648;
        a = alpha_reg;
        if (a > 65536) a = 65536;
        filt_l = (a * raw_l + (65536 - a) * longint'($signed(vel_filt))) >>> 16;
        vel_raw    = raw_l[VEL_W-1:0];
        vel_filt   = filt_l[VEL_W-1:0];
        rev_dir    = filt_l < 0;
        sample_pos = p;
        r.vf = vel_filt;
        r.vr = vel_raw;
      end
    end
    r.pin = '0;
    r.ang = '0;
    if (cpr_reg != '0) begin
      cpr_l = cpr_reg;
      deg   = DEG_SCALE;
      rem   = longint'($signed(p)) % cpr_l;
      if (rem < 0) rem += cpr_l;
      r.pin = CPR_W'(rem);
      r.ang = ANG_W'((rem * deg) / cpr_l);
    end
    r.pos = p;
    r.rev = rev_dir;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    track_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata[63:0], '0);
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[OUT_POS_LSB +: POS_W] !== e.pos)
          report_mismatch("position", m_axis_tdata[OUT_POS_LSB +: POS_W], e.pos);
        if (m_axis_tdata[OUT_PIN_LSB +: CPR_W] !== e.pin)
          report_mismatch("position_in_rev", m_axis_tdata[OUT_PIN_LSB +: CPR_W], e.pin);
        if (m_axis_tdata[OUT_ANG_LSB +: ANG_W] !== e.ang)
          report_mismatch("angle_degrees", m_axis_tdata[OUT_ANG_LSB +: ANG_W], e.ang);
        if (m_axis_tdata[OUT_VF_LSB +: VEL_W] !== e.vf)
          report_mismatch("velocity_filtered", m_axis_tdata[OUT_VF_LSB +: VEL_W], e.vf);
        if (m_axis_tdata[OUT_VR_LSB +: VEL_W] !== e.vr)
          report_mismatch("unfiltered velocity", m_axis_tdata[OUT_VR_LSB +: VEL_W], e.vr);
        if (m_axis_tdata[OUT_REV_BIT] !== e.rev)
          report_mismatch("reverse", m_axis_tdata[OUT_REV_BIT], e.rev);
      end
    end
  end

  // receiver: random stall styles, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (hold_requests != holds_served) begin
      holds_served  <= holds_served + 1;
      stall_left    <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(20, 200);
      end else begin
        style_left <= style_left - 1;
      end
      m_axis_tready <= ($urandom_range(0, 3) >= stall_style);
    end
  end

  // watchdog: cycles without any transfer or register write
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAIL encoder_position_velocity_tracker");
      $finish;
    end
  end

  // end a burst now and then with a random gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_event(mode_e mode, logic [CNT_W-1:0] cnt, logic down);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= IN_DATA_W'({down, cnt});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(track_event(mode, cnt, down));
    sent_items++;
    pace();
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // the caller drops the write enable after its last write
  task automatic set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_CPR:   cpr_reg   = value[CPR_W-1:0];
      CFG_RPC:   rpc_reg   = value[RPC_W-1:0];
      CFG_ALPHA: alpha_reg = value[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] cpr, logic [31:0] rpc, logic [31:0] alpha);
    drain();
    set_reg(CFG_CPR, cpr);
    set_reg(CFG_RPC, rpc);
    set_reg(CFG_ALPHA, alpha);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_event(MODE_READ, 16'h0000, 1'b0);
    send_event(MODE_READ, 16'hFFFF, 1'b1);
    send_event(MODE_WRAP, 16'h0000, 1'b0);
    send_event(MODE_VEL, 16'h0010, 1'b0);
    send_event(MODE_VEL, 16'h0010, 1'b0);
    send_event(MODE_WRAP, 16'hFFFF, 1'b1);
    send_event(MODE_WRAP, 16'hFFFF, 1'b1);
    send_event(MODE_READ, 16'h8000, 1'b0);
    send_event(MODE_VEL, 16'h8000, 1'b1);
    send_event(MODE_VEL, 16'h7FFF, 1'b0);
    send_event(MODE_RESET, 16'hFFFF, 1'b1);
    send_event(MODE_READ, 16'h0640, 1'b0);
    send_event(MODE_VEL, 16'h0001, 1'b0);
    send_event(MODE_READ, 16'h063F, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes();
    logic [31:0] cpr_set   [7] = '{1, 262140, 262143, 0, 3, 1600, 1600};
    logic [31:0] rpc_set   [7] = '{32'hFFFF_FFFF, 1, 0, 245760, 32'h8000_0000, 0, 245760};
    logic [31:0] alpha_set [7] = '{0, 65536, 32'h1_FFFF, 19661, 1, 65536, 19661};
    for (int s = 0; s < 7; s++) begin
      set_all(cpr_set[s], rpc_set[s], alpha_set[s]);
      send_event(MODE_RESET, 16'($urandom), 1'($urandom_range(0, 1)));
      send_event(MODE_VEL, 16'hFFFF, 1'b0);
      send_event(MODE_WRAP, 16'($urandom), 1'b1);
      send_event(MODE_WRAP, 16'($urandom), 1'b1);
      send_event(MODE_VEL, 16'h0000, 1'b0);
      send_event(MODE_VEL, 16'($urandom), 1'b0);
      send_event(MODE_READ, 16'($urandom), 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  // keep offering while the receiver holds off, so the input stalls
  task automatic test_output_holdoff();
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 8; i++) begin
      send_event(mode_e'($urandom_range(0, 2)), 16'($urandom), 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  task automatic test_random_motion();
    int stop_at, next_cfg, pos_cnt, nxt, step, sel;
    stop_at  = sent_items + 900;
    next_cfg = sent_items + 150;
    pos_cnt  = 0;
    while (sent_items < stop_at) begin
      if (sent_items >= next_cfg) begin
        next_cfg += 150;
        case ($urandom_range(0, 3))
          0: set_all($urandom_range(1, 64), $urandom, $urandom_range(0, 65536));
          1: set_all($urandom_range(1, 262143), $urandom_range(0, 1 << 20), 65536);
          2: set_all(1600, 245760, $urandom_range(0, 131071));
          default: set_all($urandom_range(1, 5000), $urandom_range(1, 1 << 18),
                           $urandom_range(1, 65535));
        endcase
      end else if ($urandom_range(0, 99) == 0) begin
        drain();
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        // well-formed motion: wrap event on crossing, then a read or a sample
        step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60000) - 30000
                                           : $urandom_range(0, 600) - 300;
        nxt = pos_cnt + step;
        if (nxt > 65535) begin
          nxt -= 65536;
          send_event(MODE_WRAP, nxt[15:0], 1'b0);
        end else if (nxt < 0) begin
          nxt += 65536;
          send_event(MODE_WRAP, nxt[15:0], 1'b1);
        end
        pos_cnt = nxt;
        send_event($urandom_range(0, 1) ? MODE_VEL : MODE_READ, pos_cnt[15:0],
                   1'($urandom_range(0, 1)));
      end else if (sel < 73) begin
        send_event(MODE_RESET, 16'($urandom), 1'($urandom_range(0, 1)));
        pos_cnt = 0;
      end else begin
        send_event(mode_e'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    drain();
  endtask

  // walk the wrap count well below zero and back up past it; zero counts
  // per revolution keeps each event short
  task automatic test_wrap_rollover();
    set_all(0, 32'hFFFF_FFFF, 32'h8000);
    send_event(MODE_RESET, 16'h0000, 1'b0);
    for (int i = 0; i < 40; i++) begin
      if (i % 8 == 0) send_event(MODE_VEL, 16'($urandom), 1'b0);
      send_event(MODE_WRAP, 16'($urandom), 1'b1);
    end
    for (int i = 0; i < 48; i++) begin
      if (i % 8 == 0) send_event(MODE_VEL, 16'($urandom), 1'b0);
      send_event(MODE_WRAP, 16'($urandom), 1'b0);
    end
    send_event(MODE_READ, 16'hFFFF, 1'b0);
    send_event(MODE_VEL, 16'h0000, 1'b0);
    send_event(MODE_WRAP, 16'h1234, 1'b1);
    send_event(MODE_WRAP, 16'h1234, 1'b1);
    send_event(MODE_VEL, 16'hFFFF, 1'b0);
    set_all(1600, 245760, 19661);
    send_event(MODE_READ, 16'($urandom), 1'b0);
    send_event(MODE_RESET, 16'($urandom), 1'b0);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_output_holdoff();
    test_random_motion();
    test_wrap_rollover();
    repeat (100) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", pending_results.size(), 0);
    end
    if (mismatches == 0) begin
      $display("PASS encoder_position_velocity_tracker");
    end else begin
      $display("FAIL encoder_position_velocity_tracker");
    end
    $finish;
  end

endmodule
